// ===== src/cfq_pkg.sv =====
// Shared types and constants for the circular FIFO queue unit.
// Depends on nothing; cfq_if, cfq_front, cfq_back and the top use scoped names, the testbench imports it.
package cfq_pkg;

    // Default ring capacity, in words
    localparam int DEPTH_DEF = 8;

    // Word width of stored and returned values
    localparam int WORD_W = 32;

    // Entries in the command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Request operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DATA = 1'b1
    } bk_state_t;

    // Command handed from the front to the back
    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

endpackage

// ===== src/cfq_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on cfq_pkg for the word width.
interface cfq_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        func;
    logic signed [cfq_pkg::WORD_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cfq_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [cfq_pkg::WORD_W-1:0] data;
    logic                              last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== src/cfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cfq_front.sv =====
// Request front end: accepts requests, drops unused codes, queues commands.
// Depends on cfq_pkg and cfq_in_if.
module cfq_front (
    input  logic          clk,
    input  logic          rst_n,
    cfq_in_if.sink        req,
    output cfq_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    cfq_pkg::cmd_t                      q_reg [cfq_pkg::CMDQ_DEPTH];
    logic [cfq_pkg::CMDQ_IDX_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [cfq_pkg::CMDQ_IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [cfq_pkg::CMDQ_CNT_W-1:0]     count_reg, count_next;
    logic                               accept;
    logic                               push;
    logic                               pop;
    cfq_pkg::op_t                       op_in;

    localparam logic [cfq_pkg::CMDQ_CNT_W-1:0] FULL_CNT =
        cfq_pkg::CMDQ_CNT_W'(cfq_pkg::CMDQ_DEPTH);
    localparam logic [cfq_pkg::CMDQ_IDX_W-1:0] LAST_IDX =
        cfq_pkg::CMDQ_IDX_W'(cfq_pkg::CMDQ_DEPTH - 1);

    // Classify: the unused code is accepted and dropped
    assign op_in     = cfq_pkg::op_t'(req.func);
    assign req.ready = (count_reg != FULL_CNT);
    assign accept    = req.valid && req.ready;
    assign push      = accept && (op_in != cfq_pkg::OP_NONE);
    assign pop       = cmd_pop && (count_reg != '0);

    // Head of queue toward the back end
    always_comb
    begin
        cmd       = q_reg[rd_ptr_reg];
        cmd.valid = (count_reg != '0);
    end

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].valid <= 1'b1;
            q_reg[wr_ptr_reg].op    <= op_in;
            q_reg[wr_ptr_reg].value <= req.value;
        end
    end

endmodule

// ===== src/cfq_back.sv =====
// Back end: owns head/tail/empty, drives the slot RAM and the result register.
// Depends on cfq_pkg, cfq_out_if and cfq_ram.
module cfq_back #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    cfq_out_if.source     rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    cfq_pkg::bk_state_t             state_reg, state_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic                           empty_reg, empty_next;
    logic [AW-1:0]                  ptr_reg, ptr_next;
    cfq_pkg::op_t                   op_reg, op_next;
    logic                           out_valid_reg, out_valid_next;
    cfq_pkg::status_t               out_status_reg, out_status_next;
    logic [cfq_pkg::WORD_W-1:0]     out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    logic                           can_load;
    logic                           load;
    logic                           we;
    logic [AW-1:0]                  waddr;
    logic                           re;
    logic [AW-1:0]                  raddr;
    logic [cfq_pkg::WORD_W-1:0]     rdata;
    logic [AW-1:0]                  tail_inc;
    logic [AW-1:0]                  head_inc;
    logic [AW-1:0]                  ptr_inc;
    logic                           start_read;
    logic                           data_done;

    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign ptr_inc  = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;

    // Result register is free or drains this cycle
    assign can_load = !out_valid_reg || rsp.ready;

    // A remove or list on a non-empty ring needs a RAM read
    assign start_read = (state_reg == cfq_pkg::BK_IDLE) && cmd.valid && can_load
                        && !empty_reg
                        && (cmd.op == cfq_pkg::OP_REMOVE || cmd.op == cfq_pkg::OP_LIST);
    // Final word of a remove or list goes out
    assign data_done  = (state_reg == cfq_pkg::BK_DATA) && can_load
                        && (op_reg == cfq_pkg::OP_REMOVE || ptr_reg == tail_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfq_pkg::BK_IDLE:
            begin
                if (start_read)
                begin
                    state_next = cfq_pkg::BK_DATA;
                end
            end
            cfq_pkg::BK_DATA:
            begin
                if (data_done)
                begin
                    state_next = cfq_pkg::BK_IDLE;
                end
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        load            = 1'b0;
        cmd_pop         = 1'b0;
        we              = 1'b0;
        waddr           = tail_inc;
        re              = 1'b0;
        raddr           = head_reg;

        unique case (state_reg)
            cfq_pkg::BK_IDLE:
            begin
                if (cmd.valid && can_load)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        cfq_pkg::OP_INSERT:
                        begin
                            load            = 1'b1;
                            out_status_next = cfq_pkg::ST_OK;
                            out_data_next   = '0;
                            out_last_next   = 1'b1;
                            if (empty_reg)
                            begin
                                we         = 1'b1;
                                waddr      = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end
                            else if (tail_inc == head_reg)
                            begin
                                out_status_next = cfq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                we        = 1'b1;
                                tail_next = tail_inc;
                            end
                        end
                        cfq_pkg::OP_REMOVE, cfq_pkg::OP_LIST:
                        begin
                            if (empty_reg)
                            begin
                                load            = 1'b1;
                                out_status_next = cfq_pkg::ST_EMPTY;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                re       = 1'b1;
                                raddr    = head_reg;
                                ptr_next = head_reg;
                                op_next  = cmd.op;
                            end
                        end
                        default:
                        begin
                            // unused code never queued; pop it silently
                        end
                    endcase
                end
            end
            cfq_pkg::BK_DATA:
            begin
                if (can_load)
                begin
                    load            = 1'b1;
                    out_status_next = cfq_pkg::ST_OK;
                    out_data_next   = rdata;
                    if (op_reg == cfq_pkg::OP_REMOVE)
                    begin
                        out_last_next = 1'b1;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_inc;
                        end
                    end
                    else
                    begin
                        out_last_next = (ptr_reg == tail_reg);
                        if (ptr_reg != tail_reg)
                        begin
                            // fetch the next listed word
                            re       = 1'b1;
                            raddr    = ptr_inc;
                            ptr_next = ptr_inc;
                        end
                    end
                end
            end
        endcase
    end

    // Result valid
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfq_pkg::BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            ptr_reg       <= '0;
            op_reg        <= cfq_pkg::OP_REMOVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            ptr_reg       <= ptr_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

    // Slot storage
    cfq_ram #(
        .WIDTH (cfq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

// ===== src/circular_fifo_queue_unit.sv =====
// Top level of the circular FIFO queue unit: front end, command queue, back end.
// Depends on cfq_pkg, cfq_if, cfq_front, cfq_back and cfq_ram.
//
//   Channel | Dir | Handshake   | Payload
//   req     | in  | valid/ready | func[1:0], value[31:0] signed
//   rsp     | out | valid/ready | status[1:0], data[31:0] signed, last
//
// Insert, and remove or list on an empty ring, are answered from the idle state.
// Remove reads the slot RAM (registered read) in idle and answers in the data state;
// list gives n held words, one per cycle from the slot RAM read port unless rsp stalls.
// The front accepts a request per cycle until its two-entry command queue fills.
// rst_n is asynchronous: both queues empty, ring empty, head and tail at zero.
// A stalled rsp holds the result register and pauses the back end.
module circular_fifo_queue_unit #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfq_in_if.sink     req,
    cfq_out_if.source  rsp
);

    cfq_pkg::cmd_t cmd;
    logic          cmd_pop;

    cfq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cmd     (cmd),
        .cmd_pop (cmd_pop)
    );

    cfq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cmd_pop (cmd_pop),
        .rsp     (rsp)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for circular_fifo_queue_unit: insert, remove and list requests.
// Depends on src/cfq_pkg.sv, src/cfq_if.sv and the circular_fifo_queue_unit design.
// The ring is predicted by a scoreboard class and each response is compared with it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfq_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 64;
    localparam int CYCLE_LIMIT  = 200000;

    // One expected response word
    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } ring_result_t;

    // Ring predictor and store of expected responses
    class ring_scoreboard;
        logic signed [WORD_W-1:0] slots [RING_DEPTH];
        int unsigned              head;
        int unsigned              tail;
        bit                       empty;
        ring_result_t             pending [$];
        int                       errors;
        int                       checked;
        int                       overflows;
        int                       underflows;
        int                       full_lists;

        function new();
            head       = 0;
            tail       = 0;
            empty      = 1'b1;
            errors     = 0;
            checked    = 0;
            overflows  = 0;
            underflows = 0;
            full_lists = 0;
        endfunction

        function int unsigned wrap_inc(int unsigned i);
            return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
        endfunction

        function void push(status_t st, logic signed [WORD_W-1:0] d, logic l);
            ring_result_t r;
            r.status = st;
            r.data   = d;
            r.last   = l;
            pending.push_back(r);
        endfunction

        // Update the ring for one accepted request and queue its responses
        function void note_request(logic [1:0] func, logic signed [WORD_W-1:0] value);
            int unsigned p;
            int          n;
            bit          fin;
            case (op_t'(func))
                OP_INSERT:
                begin
                    if (empty)
                    begin
                        head     = 0;
                        tail     = 0;
                        empty    = 1'b0;
                        slots[0] = value;
                        push(ST_OK, '0, 1'b1);
                    end
                    else if (wrap_inc(tail) == head)
                    begin
                        overflows++;
                        push(ST_OVERFLOW, '0, 1'b1);
                    end
                    else
                    begin
                        tail        = wrap_inc(tail);
                        slots[tail] = value;
                        push(ST_OK, '0, 1'b1);
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                    begin
                        underflows++;
                        push(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        push(ST_OK, slots[head], 1'b1);
                        // taking the only word empties the ring and rewinds both indices
                        if (head == tail)
                        begin
                            head  = 0;
                            tail  = 0;
                            empty = 1'b1;
                        end
                        else
                            head = wrap_inc(head);
                    end
                end
                OP_LIST:
                begin
                    if (empty)
                    begin
                        underflows++;
                        push(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        p   = head;
                        n   = 0;
                        fin = 1'b0;
                        while (!fin)
                        begin
                            fin = (p == tail) || (n == RING_DEPTH - 1);
                            push(ST_OK, slots[p], fin);
                            n++;
                            p = wrap_inc(p);
                        end
                        if (n == RING_DEPTH)
                            full_lists++;
                    end
                end
                default:
                begin
                    // unused selector: no state change, no response
                end
            endcase
        endfunction

        // Compare one accepted response with the oldest expectation
        function void check_result(logic [1:0] status, logic signed [WORD_W-1:0] data,
                                   logic last);
            ring_result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response status=%0d data=%0d last=%0d",
                         $time, status, data, last);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (status !== exp_r.status)
            begin
                errors++;
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, exp_r.status, status);
            end
            if (data !== exp_r.data)
            begin
                errors++;
                $display("%0t: data mismatch expected=%0d actual=%0d",
                         $time, exp_r.data, data);
            end
            if (last !== exp_r.last)
            begin
                errors++;
                $display("%0t: last mismatch expected=%0d actual=%0d",
                         $time, exp_r.last, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cfq_in_if  req_if ();
    cfq_out_if rsp_if ();

    circular_fifo_queue_unit #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    ring_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req_count;
    int hold_seen;
    int hold_left;
    int cycles;
    int requests_sent;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Known values on every input from time zero
    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.func    = OP_NONE;
        req_if.value   = '0;
        rsp_if.ready   = 1'b0;
        recv_stall_pct = 0;
        hold_req_count = 0;
        hold_seen      = 0;
        hold_left      = 0;
        cycles         = 0;
    end

    // Cycle budget
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, sb.pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Response side: check accepted words, then drive ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.status, rsp_if.data, rsp_if.last);
            if (hold_seen != hold_req_count)
            begin
                hold_seen = hold_req_count;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request after a random gap; returns at the accepting edge with valid high
    task automatic send_request(input op_t op, input logic signed [WORD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= op;
        req_if.value <= value;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(op, value);
        requests_sent++;
    endtask

    // Random request stream, in runs biased toward filling the ring, draining it or neither
    task automatic send_random(input int count);
        int                       bias;
        int                       roll;
        int                       sent;
        op_t                      op;
        logic signed [WORD_W-1:0] word;
        sent = 0;
        bias = 0;
        while (sent < count)
        begin
            if (sent % 16 == 0)
                bias = $urandom_range(2);
            roll = $urandom_range(99);
            case (bias)
                1:       op = (roll < 65) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                              (roll < 96) ? OP_LIST : OP_NONE;
                2:       op = (roll < 25) ? OP_INSERT : (roll < 75) ? OP_REMOVE :
                              (roll < 96) ? OP_LIST : OP_NONE;
                default: op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                              (roll < 96) ? OP_LIST : OP_NONE;
            endcase
            case ($urandom_range(9))
                0:       word = 32'sh7fff_ffff;
                1:       word = 32'sh8000_0000;
                2:       word = -32'sd1;
                3:       word = '0;
                default: word = $urandom;
            endcase
            send_request(op, word);
            if (op != OP_NONE)
                sent++;
        end
    endtask

    // Main sequence
    initial
    begin
        send_idle_pct = 0;
        requests_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, the single-word case, fill, overflow, full list, wrap
        send_request(OP_REMOVE, '0);
        send_request(OP_LIST, '0);
        send_request(OP_INSERT, 32'sh7fff_ffff);
        send_request(OP_LIST, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, 32'sh7fff_ffff);
        send_request(OP_INSERT, 32'sh5555_5555);
        send_request(OP_INSERT, 32'sh2aaa_aaaa);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, 32'sh1234_5678);
        send_request(OP_INSERT, 32'sh0bad_cafe);
        send_request(OP_LIST, '0);
        send_request(OP_NONE, 32'sh7fff_ffff);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_INSERT, -32'sd2);
        send_request(OP_INSERT, 32'sd2);
        send_request(OP_LIST, '0);

        // Phase 1, no idling; responses held off so the unit backs up into its input
        hold_req_count <= hold_req_count + 1;
        recv_stall_pct <= 0;
        send_idle_pct   = 0;
        send_random(PHASE_ITEMS);

        // Phase 2, sender idle most cycles
        recv_stall_pct <= 0;
        send_idle_pct   = 64;
        send_random(PHASE_ITEMS);

        // Phase 3, receiver stalls most cycles
        recv_stall_pct <= 64;
        send_idle_pct   = 0;
        send_random(PHASE_ITEMS);

        // Phase 4, light idling on both sides
        recv_stall_pct <= 15;
        send_idle_pct   = 15;
        send_random(PHASE_ITEMS);

        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses in %0d cycles.",
                 requests_sent, sb.checked, cycles);
        $display("Saw %0d overflows, %0d empty responses and %0d full-ring lists.",
                 sb.overflows, sb.underflows, sb.full_lists);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
